// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/scs_pkg.sv =====
// Shared constants, codes and controller/datapath types for the scanner.
// No dependencies.
package scs_pkg;

  localparam int unsigned NumOutputs  = 16;
  localparam int unsigned GroupSplit  = 8;
  localparam int unsigned MaxSamples  = 4095;

  localparam int unsigned IdxW   = 4;
  localparam int unsigned ValW   = 12;
  localparam int unsigned SumW   = 24;
  localparam int unsigned CntW   = 12;
  localparam int unsigned MaskW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ValW-1:0] ThresholdReset = 12'd5;
  localparam logic [IdxW-1:0] FirstReset     = 4'd0;
  localparam logic [IdxW-1:0] LastReset      = 4'd15;

  // action codes
  localparam logic ActTick   = 1'b0;
  localparam logic ActSample = 1'b1;

  // group codes
  localparam logic GroupA = 1'b0;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFirstIndex = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLastIndex  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThreshold  = 2'd2;

  typedef struct packed {
    logic accum;         // sample beat accepted
    logic start;         // start-phase tick
    logic div_go;        // finish tick with samples: launch divide
    logic finish_empty;  // finish tick, zero count
    logic finish_quot;   // divide done, finish with quotient
  } dp_cmd_t;

  typedef struct packed {
    logic converting;
    logic cnt_zero;      // count of the current index's group is zero
    logic div_done;
  } dp_sts_t;

  typedef struct packed {
    logic [IdxW-1:0]  scan_position;
    logic             sense_active;
    logic [ValW-1:0]  average_reading;
    logic             no_samples;
    logic [MaskW-1:0] error_mask;
  } res_t;

endpackage

// ===== rtl/core/scs_if.sv =====
// Valid/ready channel interfaces for scanner input and result beats.
// Depends on nothing.
interface scs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        sample_group;
  logic [11:0] sample_value;

  modport source (output valid, action, sample_group, sample_value, input ready);
  modport sink   (input valid, action, sample_group, sample_value, output ready);
endinterface

interface scs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  scan_position;
  logic        sense_active;
  logic [11:0] average_reading;
  logic        no_samples;
  logic [15:0] error_mask;

  modport source (output valid, scan_position, sense_active, average_reading, no_samples,
                  error_mask, input ready);
  modport sink   (input valid, scan_position, sense_active, average_reading, no_samples,
                  error_mask, output ready);
endinterface

// ===== rtl/core/scs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on scs_pkg. Caller guarantees quotient < 2**ValW.
module scs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [scs_pkg::SumW-1:0]   dividend_i,
  input  logic [scs_pkg::CntW-1:0]   divisor_i,
  output logic                       done_o,
  output logic [scs_pkg::ValW-1:0]   quot_o
);
  import scs_pkg::*;

  localparam int unsigned StepW = $clog2(ValW);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [ValW-1:0]  low_q, low_d;
  logic [CntW-1:0]  den_q;
  logic [CntW:0]    trial;
  logic             qbit;

  always_comb begin
    trial = {rem_q, low_q[ValW-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? CntW'(trial - {1'b0, den_q}) : trial[CntW-1:0];
    low_d = {low_q[ValW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(ValW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // upper dividend half is below the divisor, so it seeds the remainder
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= dividend_i[SumW-1:ValW];
      low_q <= dividend_i[ValW-1:0];
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule

// ===== rtl/core/scs_dp.sv =====
// Scanner datapath: config registers, sums/counts, scan index, error mask,
// result register. Depends on scs_pkg and scs_div.
module scs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scs_pkg::ValW-1:0]      cfg_data_i,
  input  logic                          sample_group_i,
  input  logic [scs_pkg::ValW-1:0]      sample_value_i,
  input  scs_pkg::dp_cmd_t              cmd_i,
  output scs_pkg::dp_sts_t              sts_o,
  output scs_pkg::res_t                 res_o
);
  import scs_pkg::*;

  logic [IdxW-1:0]  first_q, last_q;
  logic [ValW-1:0]  thresh_q;
  logic             conv_q;
  logic [IdxW-1:0]  scan_q, scan_d;
  logic [SumW-1:0]  sum_a_q, sum_b_q;
  logic [CntW-1:0]  cnt_a_q, cnt_b_q;
  logic [MaskW-1:0] mask_q, mask_d;
  res_t             res_q;

  logic             sel_a;
  logic [SumW-1:0]  sel_sum;
  logic [CntW-1:0]  sel_cnt;
  logic             div_done;
  logic [ValW-1:0]  quot;
  logic [ValW-1:0]  avg;
  logic             finish;
  logic [IdxW:0]    nxt;

  assign sel_a   = (scan_q < IdxW'(GroupSplit));
  assign sel_sum = sel_a ? sum_a_q : sum_b_q;
  assign sel_cnt = sel_a ? cnt_a_q : cnt_b_q;
  assign finish  = cmd_i.finish_empty | cmd_i.finish_quot;
  assign avg     = cmd_i.finish_quot ? quot : '0;

  scs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .dividend_i (sel_sum),
    .divisor_i  (sel_cnt),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    mask_d = mask_q;
    if ({1'b0, scan_q} < (IdxW+1)'(NumOutputs)) begin
      mask_d[scan_q] = (avg >= thresh_q);
    end
    nxt    = {1'b0, scan_q} + (IdxW+1)'(1);
    scan_d = nxt[IdxW-1:0];
    if (nxt > {1'b0, last_q} || nxt >= (IdxW+1)'(NumOutputs)) begin
      scan_d = first_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= FirstReset;
      last_q   <= LastReset;
      thresh_q <= ThresholdReset;
      conv_q   <= 1'b0;
      scan_q   <= FirstReset;
      sum_a_q  <= '0;
      sum_b_q  <= '0;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      mask_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFirstIndex: begin
            first_q <= cfg_data_i[IdxW-1:0];
            if (!conv_q) begin
              scan_q <= cfg_data_i[IdxW-1:0];
            end
          end
          CfgLastIndex: last_q   <= cfg_data_i[IdxW-1:0];
          CfgThreshold: thresh_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accum && conv_q) begin
        if (sample_group_i == GroupA) begin
          if (cnt_a_q < CntW'(MaxSamples)) begin
            sum_a_q <= sum_a_q + SumW'(sample_value_i);
            cnt_a_q <= cnt_a_q + CntW'(1);
          end
        end else begin
          if (cnt_b_q < CntW'(MaxSamples)) begin
            sum_b_q <= sum_b_q + SumW'(sample_value_i);
            cnt_b_q <= cnt_b_q + CntW'(1);
          end
        end
      end
      if (cmd_i.start) begin
        conv_q  <= 1'b1;
        sum_a_q <= '0;
        sum_b_q <= '0;
        cnt_a_q <= '0;
        cnt_b_q <= '0;
      end
      if (finish) begin
        conv_q <= 1'b0;
        mask_q <= mask_d;
        scan_q <= scan_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      res_q.scan_position   <= scan_q;
      res_q.sense_active    <= 1'b1;
      res_q.average_reading <= '0;
      res_q.no_samples      <= 1'b0;
      res_q.error_mask      <= mask_q;
    end else if (finish) begin
      res_q.scan_position   <= scan_q;
      res_q.sense_active    <= 1'b0;
      res_q.average_reading <= avg;
      res_q.no_samples      <= cmd_i.finish_empty;
      res_q.error_mask      <= mask_d;
    end
  end

  assign sts_o.converting = conv_q;
  assign sts_o.cnt_zero   = (sel_cnt == '0);
  assign sts_o.div_done   = div_done;
  assign res_o            = res_q;

endmodule

// ===== rtl/core/scs_ctrl.sv =====
// Scanner controller: input handshake, phase decode, divide wait, result valid.
// Depends on scs_pkg.
module scs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_action_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  scs_pkg::dp_sts_t  sts_i,
  output scs_pkg::dp_cmd_t  cmd_o
);
  import scs_pkg::*;

  typedef enum logic {StIdle, StDivide} state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   tick;

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign tick       = accept && (in_action_i == ActTick);

  always_comb begin
    cmd_o.accum        = accept && (in_action_i == ActSample);
    cmd_o.start        = tick && !sts_i.converting;
    cmd_o.div_go       = tick && sts_i.converting && !sts_i.cnt_zero;
    cmd_o.finish_empty = tick && sts_i.converting && sts_i.cnt_zero;
    cmd_o.finish_quot  = (state_q == StDivide) && sts_i.div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (cmd_o.div_go) begin
            state_q <= StDivide;
          end
        end
        StDivide: begin
          if (sts_i.div_done) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (cmd_o.start || cmd_o.finish_empty || cmd_o.finish_quot) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/switch_current_sense_scanner_top.sv =====
// Scans switch outputs one at a time for overcurrent. A sample beat gives no
// result. A start-phase tick, or a finish-phase tick whose group saw no
// samples, gives one result beat. A finish-phase tick with samples launches
// the 12-step, one-bit-per-cycle divider that forms the group average, then
// loads the result; no new beat is taken meanwhile. A new beat is taken while
// a result is pending only if that result leaves in the same cycle.
// Configuration writes are taken at any time but belong in idle.
// Depends on scs_pkg, scs_if, scs_ctrl, scs_dp, scs_div.
module switch_current_sense_scanner_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [scs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [scs_pkg::ValW-1:0]     cfg_data_i,
  scs_in_if.sink                       in_i,
  scs_out_if.source                    out_o
);
  import scs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t    res;

  scs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_group_i (in_i.sample_group),
    .sample_value_i (in_i.sample_value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .res_o          (res)
  );

  assign out_o.scan_position   = res.scan_position;
  assign out_o.sense_active    = res.sense_active;
  assign out_o.average_reading = res.average_reading;
  assign out_o.no_samples      = res.no_samples;
  assign out_o.error_mask      = res.error_mask;

endmodule

// ===== rtl/core/scs_checker.sv =====
// Port-level checks for the scanner top, attached by bind.
// Depends on assert_macros.svh and switch_current_sense_scanner_top.
`include "assert_macros.svh"

module scs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_sense_i,
  input logic [11:0] out_avg_i,
  input logic        out_empty_i,
  input logic [15:0] out_mask_i
);

  // a stalled result beat stays valid and holds its mask and average
  `SCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_mask_i) && $stable(out_avg_i), "result beat changed while stalled")

  // no new beat is taken while a result is stuck
  `SCS_ASSERT_IMPLY(a_in_blocked, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i, "input taken while result stalled")

  // sample beats never produce a result
  `SCS_ASSERT_NEXT(a_sample_silent, clk_i, rst_ni, in_valid_i && in_ready_i && in_action_i, !out_valid_i, "result after sample beat")

  // start-phase results carry no reading
  `SCS_ASSERT_IMPLY(a_start_clean, clk_i, rst_ni, out_valid_i && out_sense_i, out_avg_i == 12'd0 && !out_empty_i, "start beat with reading")

  // an empty group reports zero
  `SCS_ASSERT_IMPLY(a_empty_zero, clk_i, rst_ni, out_valid_i && out_empty_i, out_avg_i == 12'd0, "empty group with nonzero average")

endmodule

bind switch_current_sense_scanner_top scs_checker u_scs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_sense_i (out_o.sense_active),
  .out_avg_i   (out_o.average_reading),
  .out_empty_i (out_o.no_samples),
  .out_mask_i  (out_o.error_mask)
);
